[src/nscm_pkg.sv]
// shared types and constants for the note sequence chord matcher
package nscm_pkg;

	// song table geometry
	localparam int MAX_EVENTS = 64;
	localparam int IDX_W = $clog2(MAX_EVENTS);
	localparam int POS_W = $clog2(MAX_EVENTS + 1);

	// field widths fixed by the interface
	localparam int ACT_W = 8;
	localparam int NOTE_W = 7;
	localparam int KEY_W = ACT_W + NOTE_W;
	localparam int ENTRY_W = KEY_W + 1;
	localparam int LEN_W = 7;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// result status codes
	localparam logic [1:0] ST_WRITTEN = 2'd0;
	localparam logic [1:0] ST_PROGRESS = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	// classified command handed from front to back
	typedef struct packed {
		logic is_note;
		logic [IDX_W-1:0] idx;
		logic [KEY_W-1:0] key;
		logic new_instant;
	} op_t;

endpackage

[src/nscm_front.sv]
// front end: accepts beats, classifies them and queues them for the back end
module nscm_front (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  logic func,
	input  logic [nscm_pkg::IDX_W-1:0] entry_index,
	input  logic [nscm_pkg::ACT_W-1:0] entry_action,
	input  logic [nscm_pkg::NOTE_W-1:0] entry_note,
	input  logic entry_new_instant,
	input  logic [nscm_pkg::ACT_W-1:0] played_action,
	input  logic [nscm_pkg::NOTE_W-1:0] played_note,
	output nscm_pkg::op_t op,
	output logic op_valid,
	input  logic op_pop
);
	import nscm_pkg::*;

	op_t slot_q [QUEUE_DEPTH];
	op_t op_in;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic push;
	logic pop;

	// classify: a load carries the table entry, a note carries the played event
	always_comb begin
		op_in.is_note = func;
		op_in.idx = entry_index;
		op_in.key = func ? {played_note, played_action} : {entry_note, entry_action};
		op_in.new_instant = entry_new_instant;
	end

	// handshake on both sides of the queue
	assign req_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push = req_valid && !req_stall;
	assign op_valid = (count_q != '0);
	assign pop = op_pop && op_valid;
	assign op = slot_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= op_in;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/nscm_back.sv]
// back end: song table, done flags, search sequencer and result register
module nscm_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [nscm_pkg::LEN_W-1:0] cfg_wdata,
	input  nscm_pkg::op_t op,
	input  logic op_valid,
	output logic op_pop,
	output logic rsp_valid,
	input  logic rsp_stall,
	output logic [1:0] status,
	output logic [nscm_pkg::POS_W-1:0] position
);
	import nscm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ISSUE = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_ADV = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [ENTRY_W-1:0] song_mem [MAX_EVENTS];
	logic [ENTRY_W-1:0] rd_data_q;
	logic [LEN_W-1:0] len_q;
	logic [2:0] state_q;
	logic [POS_W-1:0] p_q;
	logic [POS_W-1:0] i_q;
	logic [POS_W-1:0] next_i;
	logic [POS_W-1:0] n_eff;
	logic [KEY_W-1:0] key_q;
	logic [MAX_EVENTS-1:0] done_q;
	logic [1:0] res_status_q;
	logic [POS_W-1:0] res_pos_q;
	logic rsp_valid_q;
	logic [1:0] status_q;
	logic [POS_W-1:0] position_q;
	logic out_free;
	logic load_go;
	logic entry_ni;
	logic entry_hit;

	// song length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	// effective length, clamped to one and to the table size
	always_comb begin
		priority if (len_q == '0) begin
			n_eff = POS_W'(1);
		end else if (32'(len_q) > MAX_EVENTS) begin
			n_eff = POS_W'(MAX_EVENTS);
		end else begin
			n_eff = POS_W'(len_q);
		end
	end

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign op_pop = (state_q == S_IDLE) && op_valid;
	assign load_go = op_pop && !op.is_note;
	assign next_i = i_q + 1'b1;
	assign entry_ni = rd_data_q[ENTRY_W-1];
	assign entry_hit = !done_q[i_q[IDX_W-1:0]] && (rd_data_q[KEY_W-1:0] == key_q);

	// song table: one write port for loads, registered read for the search
	always_ff @(posedge clk) begin
		if (load_go) begin
			song_mem[op.idx] <= {op.new_instant, op.key};
		end
		if (state_q == S_ISSUE) begin
			rd_data_q <= song_mem[i_q[IDX_W-1:0]];
		end
	end

	// sequencer: apply loads, search the current instant, then step the pointer over done events
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			p_q <= '0;
			i_q <= '0;
			done_q <= '0;
			res_status_q <= ST_WRITTEN;
			res_pos_q <= '0;
			key_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (op_pop) begin
						key_q <= op.key;
						i_q <= p_q;
						if (!op.is_note) begin
							done_q <= '0;
							p_q <= '0;
							res_status_q <= ST_WRITTEN;
							res_pos_q <= '0;
							state_q <= S_RESULT;
						end else if (p_q >= n_eff) begin
							done_q <= '0;
							p_q <= '0;
							res_status_q <= ST_FAIL;
							res_pos_q <= '0;
							state_q <= S_RESULT;
						end else begin
							state_q <= S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					// a later entry flagged as a new instant ends the search
					priority if (i_q != p_q && entry_ni) begin
						done_q <= '0;
						p_q <= '0;
						res_status_q <= ST_FAIL;
						res_pos_q <= '0;
						state_q <= S_RESULT;
					end else if (entry_hit) begin
						done_q[i_q[IDX_W-1:0]] <= 1'b1;
						state_q <= S_ADV;
					end else if (next_i >= n_eff) begin
						done_q <= '0;
						p_q <= '0;
						res_status_q <= ST_FAIL;
						res_pos_q <= '0;
						state_q <= S_RESULT;
					end else begin
						i_q <= next_i;
						state_q <= S_ISSUE;
					end
				end
				S_ADV: begin
					priority if (p_q < n_eff && done_q[p_q[IDX_W-1:0]]) begin
						p_q <= p_q + 1'b1;
					end else if (p_q >= n_eff) begin
						done_q <= '0;
						p_q <= '0;
						res_status_q <= ST_DONE;
						res_pos_q <= '0;
						state_q <= S_RESULT;
					end else begin
						res_status_q <= ST_PROGRESS;
						res_pos_q <= p_q;
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_RESULT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && out_free) begin
			status_q <= res_status_q;
			position_q <= res_pos_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign position = position_q;

endmodule

[src/note_sequence_chord_matcher.sv]
// top level of the note sequence chord matcher
// Matches played MIDI events against a song table loaded through the same
// request channel; one response beat per request beat. A load is answered
// without a table search. A note leaves the queue, reads each table entry
// it examines through the registered read (from the progress pointer to
// the hit or to the end of the current instant), then steps the pointer
// over each done event, one flag per cycle, and finishes by registering
// the response. The song table holds up to 64 entries. A two-beat
// queue in front lets requests be taken while a response waits to be
// taken. song_length may only be written while no request is in flight.
module note_sequence_chord_matcher (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [nscm_pkg::LEN_W-1:0] cfg_wdata,
	input  logic req_valid,
	output logic req_stall,
	input  logic func,
	input  logic [nscm_pkg::IDX_W-1:0] entry_index,
	input  logic [nscm_pkg::ACT_W-1:0] entry_action,
	input  logic [nscm_pkg::NOTE_W-1:0] entry_note,
	input  logic entry_new_instant,
	input  logic [nscm_pkg::ACT_W-1:0] played_action,
	input  logic [nscm_pkg::NOTE_W-1:0] played_note,
	output logic rsp_valid,
	input  logic rsp_stall,
	output logic [1:0] status,
	output logic [nscm_pkg::POS_W-1:0] position
);
	import nscm_pkg::*;

	op_t op;
	logic op_valid;
	logic op_pop;

	// request classification and queue
	nscm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.entry_index(entry_index),
		.entry_action(entry_action),
		.entry_note(entry_note),
		.entry_new_instant(entry_new_instant),
		.played_action(played_action),
		.played_note(played_note),
		.op(op),
		.op_valid(op_valid),
		.op_pop(op_pop)
	);

	// matching engine and response register
	nscm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.op(op),
		.op_valid(op_valid),
		.op_pop(op_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.position(position)
	);

endmodule

[src/nscm_checker.sv]
// port-level checker for the note sequence chord matcher, bound to the top level
module nscm_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input logic [1:0] status,
	input logic [nscm_pkg::POS_W-1:0] position
);
	import nscm_pkg::*;

	// no response in the cycle after reset is seen
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !rsp_valid)
		else $error("response valid during reset");

	// a stalled response beat holds its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(position))
		else $error("stalled response changed");

	// every outcome except progress leaves the pointer at zero
	a_clear_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_PROGRESS |-> position == '0)
		else $error("non-zero position on a clearing response");

	// a progress position always points inside the table
	a_prog_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_PROGRESS |-> 32'(position) < MAX_EVENTS)
		else $error("progress position outside the song");

endmodule

bind note_sequence_chord_matcher nscm_checker u_nscm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.status(status),
	.position(position)
);
